### sv/hfe_pkg.sv
package hfe_pkg;

   // Coordinate width inside the block: wide enough for a corner plus twice a span.
   localparam int CoordWidth = 7;
   localparam int PcWidth    = 5;
   localparam int AccWidth   = 36;

   // Feature kinds.
   localparam logic [2:0] KIND_TWO_H   = 3'd0;
   localparam logic [2:0] KIND_TWO_V   = 3'd1;
   localparam logic [2:0] KIND_THREE_H = 3'd2;
   localparam logic [2:0] KIND_THREE_V = 3'd3;
   localparam logic [2:0] KIND_FOUR    = 3'd4;

   // Request types.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // Microcode operations.
   localparam logic [1:0] OP_DISPATCH = 2'd0;
   localparam logic [1:0] OP_READ     = 2'd1;
   localparam logic [1:0] OP_FINISH   = 2'd2;

   // Corner row selects.
   localparam logic [1:0] R_Y1   = 2'd0;
   localparam logic [1:0] R_Y2   = 2'd1;
   localparam logic [1:0] R_Y2E  = 2'd2;
   localparam logic [1:0] R_Y2EE = 2'd3;

   // Corner column selects.
   localparam logic [1:0] C_X1   = 2'd0;
   localparam logic [1:0] C_X2   = 2'd1;
   localparam logic [1:0] C_X2D  = 2'd2;
   localparam logic [1:0] C_X2DD = 2'd3;

   // Program entry points.
   localparam logic [PcWidth-1:0] PC_DISPATCH = 5'd0;
   localparam logic [PcWidth-1:0] PC_RECT_A   = 5'd1;
   localparam logic [PcWidth-1:0] PC_FINISH   = 5'd5;
   localparam logic [PcWidth-1:0] PC_RECT_B   = 5'd6;
   localparam logic [PcWidth-1:0] PC_RECT_C   = 5'd10;
   localparam logic [PcWidth-1:0] PC_RECT_D   = 5'd14;
   localparam logic [PcWidth-1:0] PC_RECT_E   = 5'd18;
   localparam logic [PcWidth-1:0] PC_RECT_F   = 5'd22;

   typedef struct packed {
      logic              req_type;
      logic [4:0]        load_row;
      logic [4:0]        load_col;
      logic signed [31:0] load_value;
      logic [2:0]        feat_kind;
      logic [4:0]        left_col;
      logic [4:0]        top_row;
      logic [4:0]        right_col;
      logic [4:0]        bottom_row;
   } req_word_type;

   typedef struct packed {
      logic signed [AccWidth-1:0] feature_value;
      logic                       feature_ok;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [1:0]         row_sel;
      logic [1:0]         col_sel;
      logic               neg;
      logic               jump;
      logic [PcWidth-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic       rd_en;
      logic [1:0] row_sel;
      logic [1:0] col_sel;
      logic       neg;
      logic       finish;
   } seq_ctl_type;

   function automatic ucode_type uc(input logic [1:0] op, input logic [1:0] row_sel,
                                    input logic [1:0] col_sel, input logic neg,
                                    input logic jump, input logic [PcWidth-1:0] target);
      ucode_type w;
      w.op      = op;
      w.row_sel = row_sel;
      w.col_sel = col_sel;
      w.neg     = neg;
      w.jump    = jump;
      w.target  = target;
      return w;
   endfunction

   // Each rectangle is four reads: both main-diagonal corners added, the other two
   // subtracted, all flipped when the rectangle itself carries a minus sign.
   // Programs share rectangles by jumping into each other's tails.
   function automatic ucode_type ucode_rom(input logic [PcWidth-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0:  w = uc(OP_DISPATCH, R_Y1, C_X1, 1'b0, 1'b0, PC_DISPATCH);
         // Rectangle A, plus.
         5'd1:  w = uc(OP_READ, R_Y1, C_X1, 1'b0, 1'b0, PC_DISPATCH);
         5'd2:  w = uc(OP_READ, R_Y2, C_X2, 1'b0, 1'b0, PC_DISPATCH);
         5'd3:  w = uc(OP_READ, R_Y1, C_X2, 1'b1, 1'b0, PC_DISPATCH);
         5'd4:  w = uc(OP_READ, R_Y2, C_X1, 1'b1, 1'b0, PC_DISPATCH);
         5'd5:  w = uc(OP_FINISH, R_Y1, C_X1, 1'b0, 1'b0, PC_DISPATCH);
         // Rectangle B, right of A, minus.
         5'd6:  w = uc(OP_READ, R_Y1, C_X2,  1'b1, 1'b0, PC_DISPATCH);
         5'd7:  w = uc(OP_READ, R_Y2, C_X2D, 1'b1, 1'b0, PC_DISPATCH);
         5'd8:  w = uc(OP_READ, R_Y1, C_X2D, 1'b0, 1'b0, PC_DISPATCH);
         5'd9:  w = uc(OP_READ, R_Y2, C_X2,  1'b0, 1'b1, PC_RECT_A);
         // Rectangle C, below A, minus.
         5'd10: w = uc(OP_READ, R_Y2,  C_X1, 1'b1, 1'b0, PC_DISPATCH);
         5'd11: w = uc(OP_READ, R_Y2E, C_X2, 1'b1, 1'b0, PC_DISPATCH);
         5'd12: w = uc(OP_READ, R_Y2,  C_X2, 1'b0, 1'b0, PC_DISPATCH);
         5'd13: w = uc(OP_READ, R_Y2E, C_X1, 1'b0, 1'b1, PC_RECT_A);
         // Rectangle D, right of B, plus.
         5'd14: w = uc(OP_READ, R_Y1, C_X2D,  1'b0, 1'b0, PC_DISPATCH);
         5'd15: w = uc(OP_READ, R_Y2, C_X2DD, 1'b0, 1'b0, PC_DISPATCH);
         5'd16: w = uc(OP_READ, R_Y1, C_X2DD, 1'b1, 1'b0, PC_DISPATCH);
         5'd17: w = uc(OP_READ, R_Y2, C_X2D,  1'b1, 1'b1, PC_RECT_B);
         // Rectangle E, below C, plus.
         5'd18: w = uc(OP_READ, R_Y2E,  C_X1, 1'b0, 1'b0, PC_DISPATCH);
         5'd19: w = uc(OP_READ, R_Y2EE, C_X2, 1'b0, 1'b0, PC_DISPATCH);
         5'd20: w = uc(OP_READ, R_Y2E,  C_X2, 1'b1, 1'b0, PC_DISPATCH);
         5'd21: w = uc(OP_READ, R_Y2EE, C_X1, 1'b1, 1'b1, PC_RECT_C);
         // Rectangle F, diagonal of A, plus.
         5'd22: w = uc(OP_READ, R_Y2,  C_X2,  1'b0, 1'b0, PC_DISPATCH);
         5'd23: w = uc(OP_READ, R_Y2E, C_X2D, 1'b0, 1'b0, PC_DISPATCH);
         5'd24: w = uc(OP_READ, R_Y2,  C_X2D, 1'b1, 1'b0, PC_DISPATCH);
         5'd25: w = uc(OP_READ, R_Y2E, C_X2,  1'b1, 1'b0, PC_DISPATCH);
         // Second copy of rectangle B for the checkerboard, continuing into C and A.
         5'd26: w = uc(OP_READ, R_Y1, C_X2,  1'b1, 1'b0, PC_DISPATCH);
         5'd27: w = uc(OP_READ, R_Y2, C_X2D, 1'b1, 1'b0, PC_DISPATCH);
         5'd28: w = uc(OP_READ, R_Y1, C_X2D, 1'b0, 1'b0, PC_DISPATCH);
         5'd29: w = uc(OP_READ, R_Y2, C_X2,  1'b0, 1'b1, PC_RECT_C);
         default: w = uc(OP_FINISH, R_Y1, C_X1, 1'b0, 1'b0, PC_DISPATCH);
      endcase
      return w;
   endfunction

   function automatic logic [PcWidth-1:0] entry_point(input logic [2:0] kind,
                                                      input logic fits);
      logic [PcWidth-1:0] pc;
      pc = PC_FINISH;
      if (fits) begin
         unique case (kind)
            KIND_TWO_H:   pc = PC_RECT_B;
            KIND_TWO_V:   pc = PC_RECT_C;
            KIND_THREE_H: pc = PC_RECT_D;
            KIND_THREE_V: pc = PC_RECT_E;
            KIND_FOUR:    pc = PC_RECT_F;
            default:      pc = PC_FINISH;
         endcase
      end
      return pc;
   endfunction

endpackage

### sv/hfe_sequencer.sv
module hfe_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 eval_start,
   input  logic [2:0]           eval_kind,
   input  logic                 eval_fits,
   output logic                 busy,
   output hfe_pkg::seq_ctl_type ctl
);
   import hfe_pkg::*;

   logic               busy_ff, busy_in;
   logic [PcWidth-1:0] pc_ff, pc_in;
   logic [PcWidth-1:0] entry_ff, entry_in;
   ucode_type          word;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      entry_in = entry_ff;
      ctl      = '0;
      ctl.row_sel = word.row_sel;
      ctl.col_sel = word.col_sel;
      ctl.neg     = word.neg;
      if (busy_ff) begin
         unique case (word.op)
            OP_DISPATCH: pc_in = entry_ff;
            OP_READ: begin
               ctl.rd_en = 1'b1;
               pc_in     = word.jump ? word.target : pc_ff + 1'b1;
            end
            OP_FINISH: begin
               ctl.finish = 1'b1;
               busy_in    = 1'b0;
            end
            default: busy_in = 1'b0;
         endcase
      end else if (eval_start) begin
         busy_in  = 1'b1;
         pc_in    = PC_DISPATCH;
         entry_in = entry_point(eval_kind, eval_fits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pc_ff    <= PC_DISPATCH;
         entry_ff <= PC_FINISH;
      end else begin
         busy_ff  <= busy_in;
         pc_ff    <= pc_in;
         entry_ff <= entry_in;
      end
   end

   assign busy = busy_ff;

endmodule

### sv/hfe_datapath.sv
module hfe_datapath #(
   parameter int WINDOW_SIZE = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_start,
   input  logic                         eval_start,
   input  hfe_pkg::req_word_type        req,
   input  hfe_pkg::seq_ctl_type         ctl,
   output logic signed [hfe_pkg::AccWidth-1:0] acc_next
);
   import hfe_pkg::*;

   localparam int Depth = WINDOW_SIZE * WINDOW_SIZE;
   localparam int AddrWidth = $clog2(Depth);
   localparam logic [CoordWidth-1:0] WsCoord = CoordWidth'(WINDOW_SIZE);

   logic signed [31:0] integral_mem [Depth];

   logic [CoordWidth-1:0] rows_ff [4];
   logic [CoordWidth-1:0] cols_ff [4];
   logic [CoordWidth-1:0] x1, x2, y1, y2, d, e;

   logic signed [31:0]          rdata_ff;
   logic                        pend_ff, pend_in;
   logic                        pend_neg_ff;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic signed [AccWidth-1:0]  term;

   logic [AddrWidth-1:0] load_addr, read_addr, addr;
   logic                 wr_en;

   // Corner coordinates of all rectangles, taken when an evaluation is accepted.
   assign x1 = CoordWidth'(req.left_col);
   assign x2 = CoordWidth'(req.right_col);
   assign y1 = CoordWidth'(req.top_row);
   assign y2 = CoordWidth'(req.bottom_row);
   assign d  = x2 - x1;
   assign e  = y2 - y1;

   always_ff @(posedge clock) begin
      if (eval_start) begin
         rows_ff[R_Y1]   <= y1;
         rows_ff[R_Y2]   <= y2;
         rows_ff[R_Y2E]  <= y2 + e;
         rows_ff[R_Y2EE] <= y2 + e + e;
         cols_ff[C_X1]   <= x1;
         cols_ff[C_X2]   <= x2;
         cols_ff[C_X2D]  <= x2 + d;
         cols_ff[C_X2DD] <= x2 + d + d;
      end
   end

   assign load_addr = AddrWidth'(req.load_row) * AddrWidth'(WINDOW_SIZE)
                      + AddrWidth'(req.load_col);
   assign read_addr = AddrWidth'(rows_ff[ctl.row_sel]) * AddrWidth'(WINDOW_SIZE)
                      + AddrWidth'(cols_ff[ctl.col_sel]);
   assign wr_en = load_start && (CoordWidth'(req.load_row) < WsCoord)
                  && (CoordWidth'(req.load_col) < WsCoord);
   assign addr = load_start ? load_addr : read_addr;

   // Single-port integral store: loads and feature reads never share a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         integral_mem[addr] <= req.load_value;
      end
      rdata_ff <= integral_mem[addr];
   end

   assign pend_in = ctl.rd_en;
   assign term    = pend_neg_ff ? -AccWidth'(rdata_ff) : AccWidth'(rdata_ff);

   always_comb begin
      acc_next = acc_ff;
      if (pend_ff) begin
         acc_next = acc_ff + term;
      end
      acc_in = eval_start ? '0 : acc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      pend_neg_ff <= ctl.neg;
      acc_ff      <= acc_in;
   end

endmodule

### sv/haar_feature_evaluator.sv
// Haar feature evaluator. A load word (req_type 0) writes one signed 32-bit
// integral image entry into a WINDOW_SIZE by WINDOW_SIZE store in the cycle it
// is accepted; loads outside the window are dropped, produce no result and never
// raise busy. An evaluate word (req_type 1) names a feature kind and the corners
// of its first rectangle, and yields exactly one result word: the exact 36-bit
// weighted sum of the feature's rectangle sums, or zero with feature_ok low when
// the feature does not fit the window. A word is accepted when start is high
// and busy is low. An evaluation holds busy through a dispatch step, one step per
// integral read and a finish step: 8 reads for two-rectangle features, 12 for
// three-rectangle, 16 for the checkerboard and none for a feature that does not
// fit. The single-port integral memory serves one corner per cycle.
// The result word appears on rsp_word with rsp_valid high for exactly one cycle,
// the first cycle in which busy is low again; the receiver cannot stall it, so it
// must take the word in that cycle. A new word may be accepted in that same cycle.
// Entries of the store read by a feature must have been loaded since reset.
module haar_feature_evaluator #(
   parameter int WINDOW_SIZE = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hfe_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output hfe_pkg::rsp_word_type rsp_word
);
   import hfe_pkg::*;

   localparam logic [CoordWidth-1:0] WsCoord = CoordWidth'(WINDOW_SIZE);

   logic                  accept;
   logic                  load_start;
   logic                  eval_start;
   logic                  fits;
   logic                  horiz, vert;
   logic [CoordWidth-1:0] x1, x2, y1, y2, d, e;
   seq_ctl_type           ctl;
   logic signed [AccWidth-1:0] acc_next;

   logic         ok_ff, ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   assign accept     = start && !busy;
   assign load_start = accept && (req_word.req_type == REQ_LOAD);
   assign eval_start = accept && (req_word.req_type == REQ_EVAL);

   // Window fit check, done once when the evaluation is accepted.
   assign x1 = CoordWidth'(req_word.left_col);
   assign x2 = CoordWidth'(req_word.right_col);
   assign y1 = CoordWidth'(req_word.top_row);
   assign y2 = CoordWidth'(req_word.bottom_row);
   assign d  = x2 - x1;
   assign e  = y2 - y1;
   assign horiz = (req_word.feat_kind == KIND_TWO_H) || (req_word.feat_kind == KIND_THREE_H)
                  || (req_word.feat_kind == KIND_FOUR);
   assign vert  = (req_word.feat_kind == KIND_TWO_V) || (req_word.feat_kind == KIND_THREE_V)
                  || (req_word.feat_kind == KIND_FOUR);

   always_comb begin
      fits = 1'b1;
      if (req_word.feat_kind > KIND_FOUR || x1 > x2 || y1 > y2) begin
         fits = 1'b0;
      end
      if (x2 >= WsCoord || y2 >= WsCoord) begin
         fits = 1'b0;
      end
      // Spans are only meaningful once the corners are known to be ordered.
      if (horiz && (x2 + d >= WsCoord)) begin
         fits = 1'b0;
      end
      if (vert && (y2 + e >= WsCoord)) begin
         fits = 1'b0;
      end
      if (req_word.feat_kind == KIND_THREE_H && (x2 + d + d >= WsCoord)) begin
         fits = 1'b0;
      end
      if (req_word.feat_kind == KIND_THREE_V && (y2 + e + e >= WsCoord)) begin
         fits = 1'b0;
      end
   end

   hfe_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .eval_start (eval_start),
      .eval_kind  (req_word.feat_kind),
      .eval_fits  (fits),
      .busy       (busy),
      .ctl        (ctl)
   );

   hfe_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .load_start (load_start),
      .eval_start (eval_start),
      .req        (req_word),
      .ctl        (ctl),
      .acc_next   (acc_next)
   );

   // The final step folds in the last read and the sum goes straight to the
   // output register, so the result word is presented in the same cycle that
   // busy drops.
   assign ok_in        = eval_start ? fits : ok_ff;
   assign rsp_valid_in = ctl.finish;

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (ctl.finish) begin
         rsp_word_in.feature_value = acc_next;
         rsp_word_in.feature_ok    = ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
